### src/lens_distortion_coordinate_map_macros.svh
// ----------------------------------------------------------------------------
// lens distortion map assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_COORDINATE_MAP_MACROS_SVH
`define LENS_DISTORTION_COORDINATE_MAP_MACROS_SVH
`ifndef SYNTHESIS
// condition holds, consequence holds in the same cycle
`define LDCM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ldcm check failed");
// condition holds, consequence holds in the next cycle
`define LDCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ldcm check failed");
`else
`define LDCM_ASSERT_SAME(lbl, ante, cons)
`define LDCM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/ldcm_pkg.sv
// ----------------------------------------------------------------------------
// ldcm_pkg
// types, widths and helpers shared by the lens distortion map
// ----------------------------------------------------------------------------
package ldcm_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LIM_W      = 17;

    // field widths
    localparam int PIX_W     = 12;
    localparam int FOCAL_W   = 24;
    localparam int CENTER_W  = 20;
    localparam int COEF_W    = 20;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // internal widths
    localparam int NORM_W    = 28;
    localparam int NORM_FRAC = 24;
    localparam int COEF_FRAC = 16;
    localparam int LOW_W     = NORM_W - NORM_FRAC;
    localparam int DIV_STEPS = NORM_W;
    localparam int XX_W      = 33;
    localparam int R2_W      = XX_W + 1;
    localparam int R4_W      = 44;
    localparam int XD_W      = 44;
    localparam int RAD_W     = 32;
    localparam int WIDE_W    = 80;

    // pipeline depth per unit
    localparam int NORM_LAT = DIV_STEPS + 2;
    localparam int DIST_LAT = 8;
    localparam int PROJ_LAT = 2;
    localparam int PIPE_LAT = NORM_LAT + DIST_LAT + PROJ_LAT;

    // clip limits
    localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
    localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] RAD_MAX  = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] RAD_MIN  = -WIDE_W'(64'sd2147483648);
    localparam logic signed [WIDE_W-1:0] OUT_MAX  = WIDE_W'(64'sd8388607);
    localparam logic signed [WIDE_W-1:0] OUT_MIN  = -WIDE_W'(64'sd8388608);
    localparam logic signed [WIDE_W-1:0] ONE_Q24  = WIDE_W'(64'sd16777216);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X       = 3'd0,
        REG_FOCAL_Y       = 3'd1,
        REG_CENTER_X      = 3'd2,
        REG_CENTER_Y      = 3'd3,
        REG_RADIAL_K1     = 3'd4,
        REG_RADIAL_K2     = 3'd5,
        REG_TANGENTIAL_P1 = 3'd6,
        REG_TANGENTIAL_P2 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_col;
        logic [PIX_W-1:0] pixel_row;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] source_col;
        logic signed [OUT_W-1:0] source_row;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic        [FOCAL_W-1:0]  focal_x;
        logic        [FOCAL_W-1:0]  focal_y;
        logic        [CENTER_W-1:0] center_x;
        logic        [CENTER_W-1:0] center_y;
        logic signed [COEF_W-1:0]   radial_k1;
        logic signed [COEF_W-1:0]   radial_k2;
        logic signed [COEF_W-1:0]   tangential_p1;
        logic signed [COEF_W-1:0]   tangential_p2;
    } t_cfg;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic                     sat;
    } t_norm;

    typedef struct packed {
        logic signed [XD_W-1:0] xd;
        logic signed [XD_W-1:0] yd;
        logic                   sat;
    } t_dist;

    // arithmetic right shift with round half up
    function automatic logic signed [WIDE_W-1:0] rnd_shr(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              s
    );
        logic signed [WIDE_W-1:0] half;
        half = WIDE_W'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

endpackage

### src/ldcm_norm.sv
// ----------------------------------------------------------------------------
// ldcm_norm
// centers one coordinate and divides it by the focal length, one quotient
// bit per stage, result Q4.24 with clipping
// ----------------------------------------------------------------------------
module ldcm_norm (
    input  logic                                 i_clk,
    input  logic                                 i_adv,
    input  logic        [ldcm_pkg::PIX_W-1:0]    i_pix,
    input  logic        [ldcm_pkg::CENTER_W-1:0] i_center,
    input  logic        [ldcm_pkg::FOCAL_W-1:0]  i_focal,
    output logic signed [ldcm_pkg::NORM_W-1:0]   o_norm,
    output logic                                 o_sat
);
    import ldcm_pkg::*;

    logic signed [CENTER_W:0]   n_d;
    logic signed [CENTER_W:0]   n_dn;
    logic        [CENTER_W-1:0] n_mag;
    logic                       n_neg;
    logic                       n_ovf;
    logic        [FOCAL_W-1:0]  w_div;

    logic [FOCAL_W-1:0] r_rem [0:DIV_STEPS];
    logic [NORM_W-1:0]  r_q   [0:DIV_STEPS];
    logic [LOW_W-1:0]   r_low [0:DIV_STEPS];
    logic               r_neg [0:DIV_STEPS];
    logic               r_ovf [0:DIV_STEPS];

    logic signed [NORM_W-1:0] n_norm;
    logic                     n_sat;
    logic signed [NORM_W-1:0] r_norm;
    logic                     r_sat;

    // offset from principal point, magnitude and early overflow test
    always_comb begin
        n_d   = $signed({1'b0, i_pix, 8'b0}) - $signed({1'b0, i_center});
        n_dn  = -n_d;
        n_neg = n_d[CENTER_W];
        n_mag = n_neg ? n_dn[CENTER_W-1:0] : n_d[CENTER_W-1:0];
        w_div = (i_focal == '0) ? FOCAL_W'(1) : i_focal;
        n_ovf = NORM_W'(n_mag) >= {w_div, LOW_W'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= FOCAL_W'(n_mag[CENTER_W-1:LOW_W]);
            r_q[0]   <= '0;
            r_low[0] <= n_mag[LOW_W-1:0];
            r_neg[0] <= n_neg;
            r_ovf[0] <= n_ovf;
        end
    end

    // restoring divider, one step per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [FOCAL_W:0]   w_rem2;
        logic               w_ge;
        logic [FOCAL_W-1:0] n_rem;

        assign w_rem2 = {r_rem[k], r_low[k][LOW_W-1]};
        assign w_ge   = w_rem2 >= {1'b0, w_div};
        assign n_rem  = w_ge ? FOCAL_W'(w_rem2 - {1'b0, w_div}) : w_rem2[FOCAL_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k+1] <= n_rem;
                r_q[k+1]   <= {r_q[k][NORM_W-2:0], w_ge};
                r_low[k+1] <= r_low[k] << 1;
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // sign and clip
    always_comb begin
        n_sat  = 1'b0;
        n_norm = $signed(r_q[DIV_STEPS]);
        if (r_ovf[DIV_STEPS]) begin
            n_sat  = 1'b1;
            n_norm = r_neg[DIV_STEPS] ? NORM_MIN : NORM_MAX;
        end else if (!r_neg[DIV_STEPS]) begin
            if (r_q[DIV_STEPS][NORM_W-1]) begin
                n_sat  = 1'b1;
                n_norm = NORM_MAX;
            end
        end else if (r_q[DIV_STEPS] > {1'b1, {(NORM_W-1){1'b0}}}) begin
            n_sat  = 1'b1;
            n_norm = NORM_MIN;
        end else begin
            n_norm = -$signed(r_q[DIV_STEPS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_norm <= n_norm;
            r_sat  <= n_sat;
        end
    end

    assign o_norm = r_norm;
    assign o_sat  = r_sat;

endmodule

### src/ldcm_dist.sv
// ----------------------------------------------------------------------------
// ldcm_dist
// radial and tangential distortion of a normalized point, eight stages
// ----------------------------------------------------------------------------
module ldcm_dist (
    input  logic            i_clk,
    input  logic            i_adv,
    input  ldcm_pkg::t_cfg  i_cfg,
    input  ldcm_pkg::t_norm i_norm,
    output ldcm_pkg::t_dist o_dist
);
    import ldcm_pkg::*;

    // stage 1: squares and cross product
    logic signed [2*NORM_W-1:0] r1_px, r1_py, r1_pxy;
    logic signed [NORM_W-1:0]   r1_x, r1_y;
    logic                       r1_sat;

    // stage 2: rescaled squares and r2
    logic signed [XX_W-1:0]   n2_xx, n2_yy, n2_xy;
    logic signed [R2_W-1:0]   n2_r2;
    logic signed [XX_W-1:0]   r2_xx, r2_yy, r2_xy;
    logic signed [R2_W-1:0]   r2_r2;
    logic signed [NORM_W-1:0] r2_x, r2_y;
    logic                     r2_sat;

    // stage 3: r2 squared, k1 and tangential products
    logic signed [R2_W:0]            n3_ax, n3_ay;
    logic signed [2*R2_W-1:0]        r3_pr4;
    logic signed [COEF_W+R2_W-1:0]   r3_pk1;
    logic signed [COEF_W+XX_W-1:0]   r3_ptx1, r3_pty2;
    logic signed [COEF_W+R2_W:0]     r3_ptx2, r3_pty1;
    logic signed [NORM_W-1:0]        r3_x, r3_y;
    logic                            r3_sat;

    // stage 4: rescaled terms
    logic signed [R4_W-1:0]   r4_r4;
    logic signed [XD_W-1:0]   r4_kr1, r4_tx, r4_ty;
    logic signed [NORM_W-1:0] r4_x, r4_y;
    logic                     r4_sat;

    // stage 5: k2 product
    logic signed [COEF_W+R4_W-1:0] r5_pk2;
    logic signed [XD_W-1:0]        r5_kr1, r5_tx, r5_ty;
    logic signed [NORM_W-1:0]      r5_x, r5_y;
    logic                          r5_sat;

    // stage 6: radial factor
    logic signed [WIDE_W-1:0] n6_sum;
    logic signed [RAD_W-1:0]  n6_rad;
    logic                     n6_sat;
    logic signed [RAD_W-1:0]  r6_rad;
    logic signed [XD_W-1:0]   r6_tx, r6_ty;
    logic signed [NORM_W-1:0] r6_x, r6_y;
    logic                     r6_sat;

    // stage 7: radial times coordinate
    logic signed [RAD_W+NORM_W-1:0] r7_prx, r7_pry;
    logic signed [XD_W-1:0]         r7_tx, r7_ty;
    logic                           r7_sat;

    // stage 8: distorted point
    t_dist r8_dist;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_px  <= i_norm.x * i_norm.x;
            r1_py  <= i_norm.y * i_norm.y;
            r1_pxy <= i_norm.x * i_norm.y;
            r1_x   <= i_norm.x;
            r1_y   <= i_norm.y;
            r1_sat <= i_norm.sat;
        end
    end

    always_comb begin
        n2_xx = XX_W'(rnd_shr(WIDE_W'(r1_px), NORM_FRAC));
        n2_yy = XX_W'(rnd_shr(WIDE_W'(r1_py), NORM_FRAC));
        n2_xy = XX_W'(rnd_shr(WIDE_W'(r1_pxy), NORM_FRAC));
        n2_r2 = R2_W'(n2_xx) + R2_W'(n2_yy);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_xx  <= n2_xx;
            r2_yy  <= n2_yy;
            r2_xy  <= n2_xy;
            r2_r2  <= n2_r2;
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_sat <= r1_sat;
        end
    end

    always_comb begin
        n3_ax = (R2_W+1)'(r2_r2) + ((R2_W+1)'(r2_xx) <<< 1);
        n3_ay = (R2_W+1)'(r2_r2) + ((R2_W+1)'(r2_yy) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_pr4  <= r2_r2 * r2_r2;
            r3_pk1  <= i_cfg.radial_k1 * r2_r2;
            r3_ptx1 <= i_cfg.tangential_p1 * r2_xy;
            r3_ptx2 <= i_cfg.tangential_p2 * n3_ax;
            r3_pty1 <= i_cfg.tangential_p1 * n3_ay;
            r3_pty2 <= i_cfg.tangential_p2 * r2_xy;
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_sat  <= r2_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_r4  <= R4_W'(rnd_shr(WIDE_W'(r3_pr4), NORM_FRAC));
            r4_kr1 <= XD_W'(rnd_shr(WIDE_W'(r3_pk1), COEF_FRAC));
            r4_tx  <= XD_W'(rnd_shr(WIDE_W'(r3_ptx1) <<< 1, COEF_FRAC))
                    + XD_W'(rnd_shr(WIDE_W'(r3_ptx2), COEF_FRAC));
            r4_ty  <= XD_W'(rnd_shr(WIDE_W'(r3_pty1), COEF_FRAC))
                    + XD_W'(rnd_shr(WIDE_W'(r3_pty2) <<< 1, COEF_FRAC));
            r4_x   <= r3_x;
            r4_y   <= r3_y;
            r4_sat <= r3_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_pk2 <= i_cfg.radial_k2 * r4_r4;
            r5_kr1 <= r4_kr1;
            r5_tx  <= r4_tx;
            r5_ty  <= r4_ty;
            r5_x   <= r4_x;
            r5_y   <= r4_y;
            r5_sat <= r4_sat;
        end
    end

    // 1 + k1*r2 + k2*r4, clipped to 32 bits
    always_comb begin
        n6_sum = ONE_Q24 + WIDE_W'(r5_kr1) + rnd_shr(WIDE_W'(r5_pk2), COEF_FRAC);
        n6_sat = r5_sat;
        n6_rad = RAD_W'(n6_sum);
        if (n6_sum > RAD_MAX) begin
            n6_sat = 1'b1;
            n6_rad = RAD_W'(RAD_MAX);
        end else if (n6_sum < RAD_MIN) begin
            n6_sat = 1'b1;
            n6_rad = RAD_W'(RAD_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_rad <= n6_rad;
            r6_tx  <= r5_tx;
            r6_ty  <= r5_ty;
            r6_x   <= r5_x;
            r6_y   <= r5_y;
            r6_sat <= n6_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r7_prx <= r6_rad * r6_x;
            r7_pry <= r6_rad * r6_y;
            r7_tx  <= r6_tx;
            r7_ty  <= r6_ty;
            r7_sat <= r6_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r8_dist.xd  <= XD_W'(rnd_shr(WIDE_W'(r7_prx), NORM_FRAC)) + r7_tx;
            r8_dist.yd  <= XD_W'(rnd_shr(WIDE_W'(r7_pry), NORM_FRAC)) + r7_ty;
            r8_dist.sat <= r7_sat;
        end
    end

    assign o_dist = r8_dist;

endmodule

### src/ldcm_proj.sv
// ----------------------------------------------------------------------------
// ldcm_proj
// projects the distorted point back to pixels and clips to the output range
// ----------------------------------------------------------------------------
module ldcm_proj (
    input  logic            i_clk,
    input  logic            i_adv,
    input  ldcm_pkg::t_cfg  i_cfg,
    input  ldcm_pkg::t_dist i_dist,
    output ldcm_pkg::t_out  o_out
);
    import ldcm_pkg::*;

    logic signed [FOCAL_W+XD_W:0] r9_pcol, r9_prow;
    logic                         r9_sat;

    logic signed [WIDE_W-1:0] n_col, n_row;
    t_out                     n_out;
    t_out                     r_out;

    // focal length times distorted point
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r9_pcol <= $signed({1'b0, i_cfg.focal_x}) * i_dist.xd;
            r9_prow <= $signed({1'b0, i_cfg.focal_y}) * i_dist.yd;
            r9_sat  <= i_dist.sat;
        end
    end

    // rescale, add principal point, clip
    always_comb begin
        n_col = rnd_shr(WIDE_W'(r9_pcol), NORM_FRAC) + WIDE_W'($signed({1'b0, i_cfg.center_x}));
        n_row = rnd_shr(WIDE_W'(r9_prow), NORM_FRAC) + WIDE_W'($signed({1'b0, i_cfg.center_y}));
        n_out.saturated  = r9_sat;
        n_out.source_col = OUT_W'(n_col);
        n_out.source_row = OUT_W'(n_row);
        if (n_col > OUT_MAX) begin
            n_out.saturated  = 1'b1;
            n_out.source_col = OUT_W'(OUT_MAX);
        end else if (n_col < OUT_MIN) begin
            n_out.saturated  = 1'b1;
            n_out.source_col = OUT_W'(OUT_MIN);
        end
        if (n_row > OUT_MAX) begin
            n_out.saturated  = 1'b1;
            n_out.source_row = OUT_W'(OUT_MAX);
        end else if (n_row < OUT_MIN) begin
            n_out.saturated  = 1'b1;
            n_out.source_row = OUT_W'(OUT_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

### src/lens_distortion_coordinate_map.sv
// a request passes the divider, distortion and projection units in that order
// throughput: one request per cycle while the output is not stalled; the fixed-depth pipeline sets the rate
// a stalled result freezes the whole pipeline until it is taken
// reset: synchronous active-low, clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
// lens_distortion_coordinate_map
// brown-conrady k1 k2 p1 p2 coordinate map, fixed point, fully pipelined
// ----------------------------------------------------------------------------
`include "lens_distortion_coordinate_map_macros.svh"

module lens_distortion_coordinate_map (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ldcm_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ldcm_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [ldcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ldcm_pkg::CFG_W-1:0]         i_cfg_data
);
    import ldcm_pkg::*;

    t_cfg                r_cfg;
    logic [PIPE_LAT-1:0] r_v;
    logic                w_adv;
    logic                w_in_acc;
    logic [PIX_W-1:0]    n_col, n_row;
    t_norm               w_norm;
    t_dist               w_dist;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x       <= FOCAL_W'(256000);
            r_cfg.focal_y       <= FOCAL_W'(256000);
            r_cfg.center_x      <= CENTER_W'(81920);
            r_cfg.center_y      <= CENTER_W'(61440);
            r_cfg.radial_k1     <= '0;
            r_cfg.radial_k2     <= '0;
            r_cfg.tangential_p1 <= '0;
            r_cfg.tangential_p2 <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FOCAL_X:       r_cfg.focal_x       <= i_cfg_data[FOCAL_W-1:0];
                REG_FOCAL_Y:       r_cfg.focal_y       <= i_cfg_data[FOCAL_W-1:0];
                REG_CENTER_X:      r_cfg.center_x      <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:      r_cfg.center_y      <= i_cfg_data[CENTER_W-1:0];
                REG_RADIAL_K1:     r_cfg.radial_k1     <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_RADIAL_K2:     r_cfg.radial_k2     <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_TANGENTIAL_P1: r_cfg.tangential_p1 <= $signed(i_cfg_data[COEF_W-1:0]);
                REG_TANGENTIAL_P2: r_cfg.tangential_p2 <= $signed(i_cfg_data[COEF_W-1:0]);
                default: ;
            endcase
        end
    end

    // pipeline advance and valid line
    assign w_adv       = !r_v[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign w_in_acc    = i_in_valid && w_adv;
    assign o_out_valid = r_v[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[PIPE_LAT-2:0], w_in_acc};
        end
    end

    // clamp pixel to the frame
    always_comb begin
        n_col = (LIM_W'(i_in_data.pixel_col) >= LIM_W'(MAX_WIDTH))
              ? PIX_W'(MAX_WIDTH - 1) : i_in_data.pixel_col;
        n_row = (LIM_W'(i_in_data.pixel_row) >= LIM_W'(MAX_HEIGHT))
              ? PIX_W'(MAX_HEIGHT - 1) : i_in_data.pixel_row;
    end

    logic w_sat_x, w_sat_y;

    ldcm_norm u_norm_x (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_pix    (n_col),
        .i_center (r_cfg.center_x),
        .i_focal  (r_cfg.focal_x),
        .o_norm   (w_norm.x),
        .o_sat    (w_sat_x)
    );

    ldcm_norm u_norm_y (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_pix    (n_row),
        .i_center (r_cfg.center_y),
        .i_focal  (r_cfg.focal_y),
        .o_norm   (w_norm.y),
        .o_sat    (w_sat_y)
    );

    assign w_norm.sat = w_sat_x || w_sat_y;

    ldcm_dist u_dist (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_cfg  (r_cfg),
        .i_norm (w_norm),
        .o_dist (w_dist)
    );

    ldcm_proj u_proj (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_cfg  (r_cfg),
        .i_dist (w_dist),
        .o_out  (o_out_data)
    );

    // checks
    `LDCM_ASSERT_NEXT(a_accept_enters, w_in_acc, r_v[0])
    `LDCM_ASSERT_NEXT(a_stall_holds, !w_adv, $stable(r_v))
    `LDCM_ASSERT_SAME(a_ready_when_empty, !r_v[PIPE_LAT-1], o_in_ready)

endmodule
